FILE: src/htfe_pkg.sv
// Shared types, constants and helper functions for the hex-text frame extractor.
`timescale 1ns / 1ps

package htfe_pkg;

  localparam int CHAR_W    = 8;
  localparam int MARKER_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;

  localparam logic [MARKER_W-1:0] START_MARKER_RST = 32'h3930_3030;
  localparam logic [MARKER_W-1:0] END_MARKER_RST   = 32'h3064_3061;

  // One decoded result from the parser stage.
  typedef struct packed {
    logic emit;
    logic last;
    logic err;
  } htfe_res_t;

  // Character at position pos of a marker, first character in the top byte.
  function automatic logic [CHAR_W-1:0] marker_char(input logic [MARKER_W-1:0] marker,
                                                    input logic [1:0] pos);
    logic [CHAR_W-1:0] c;
    unique case (pos)
      2'd0:    c = marker[31:24];
      2'd1:    c = marker[23:16];
      2'd2:    c = marker[15:8];
      default: c = marker[7:0];
    endcase
    return c;
  endfunction

  // Hex digit value in bits 3:0; bit 4 set when c is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

FILE: src/htfe_in_if.sv
// Input character channel.
`timescale 1ns / 1ps

interface htfe_in_if;
  import htfe_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

FILE: src/htfe_out_if.sv
// Result channel carrying frame characters and status flags.
`timescale 1ns / 1ps

interface htfe_out_if;
  import htfe_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              frame_last;
  logic              frame_error;

  modport source (output valid, output out_char, output frame_last, output frame_error,
                  input ready);
  modport sink   (input valid, input out_char, input frame_last, input frame_error,
                  output ready);
endinterface

FILE: src/htfe_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps

interface htfe_cfg_if;
  import htfe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MARKER_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/hex_text_frame_extractor.sv
// Top level of the hex-text frame extractor: input register, parser, result register.
// A transferred character passes the input register, then the result register, to the output.
// Throughput: one char per cycle unless stalled; parser state updates once per character.
// A stalled result holds the input register; input ready drops if that register is full.
// Reset (rst_n low, synchronous): pipeline emptied, parser hunts the start marker,
// marker registers return to "9000" and "0d0a".
`timescale 1ns / 1ps

module hex_text_frame_extractor
  import htfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  htfe_in_if.sink    in_ch,
  htfe_out_if.source out_ch,
  htfe_cfg_if.sink   cfg_ch
);

  logic [MARKER_W-1:0] start_marker;
  logic [MARKER_W-1:0] end_marker;

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_fire;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              out_err_r;

  htfe_res_t res;

  htfe_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_ch),
    .start_marker (start_marker),
    .end_marker   (end_marker)
  );

  htfe_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_fire),
    .char_in      (s1_char_r),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .res          (res)
  );

  // Advance the input register whenever the result slot is free or draining.
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) s1_char_r <= in_ch.in_char;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_char_r <= s1_char_r;
      out_last_r <= res.last;
      out_err_r  <= res.err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.frame_last  = out_last_r;
  assign out_ch.frame_error = out_err_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_char_r))
    else $error("stalled result changed");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_last_r && out_err_r))
    else $error("result flagged both last and error");

  a_no_fire_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !s1_fire)
    else $error("parser advanced into an occupied result register");
`endif

endmodule

FILE: src/htfe_cfg_regs.sv
// Start and end marker registers written over the configuration channel.
`timescale 1ns / 1ps

module htfe_cfg_regs
  import htfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  htfe_cfg_if.sink             cfg,
  output logic [MARKER_W-1:0]  start_marker,
  output logic [MARKER_W-1:0]  end_marker
);

  logic [MARKER_W-1:0] start_marker_r;
  logic [MARKER_W-1:0] end_marker_r;

  assign cfg.ready    = 1'b1;
  assign start_marker = start_marker_r;
  assign end_marker   = end_marker_r;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_START_MARKER) start_marker_r <= cfg.data;
      if (cfg.index == REG_END_MARKER)   end_marker_r   <= cfg.data;
    end
  end

endmodule

FILE: src/htfe_parser.sv
// Frame parser state: marker compares, length digits and payload count.
`timescale 1ns / 1ps

module htfe_parser
  import htfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic [MARKER_W-1:0] start_marker,
  input  logic [MARKER_W-1:0] end_marker,
  output htfe_res_t           res
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_END     = 3'd4;
  localparam logic [2:0] PH_STOPPED = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [3:0] len_hi_r, len_hi_nxt;
  logic [8:0] left_r, left_nxt;

  logic [4:0] hex;
  logic [8:0] left_dec;

  assign hex      = hex_value(char_in);
  assign left_dec = left_r - 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    res        = '{emit: 1'b1, last: 1'b0, err: 1'b0};
    unique case (phase_r)
      PH_START: begin
        if (char_in != marker_char(start_marker, pos_r)) begin
          res.err   = 1'b1;
          phase_nxt = PH_STOPPED;
        end else begin
          pos_nxt = pos_r + 2'd1;
          if (pos_r == 2'd3) phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        if (hex[4]) begin
          res.err   = 1'b1;
          phase_nxt = PH_STOPPED;
        end else begin
          len_hi_nxt = hex[3:0];
          phase_nxt  = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (hex[4]) begin
          res.err   = 1'b1;
          phase_nxt = PH_STOPPED;
        end else begin
          // Payload is two characters per byte.
          left_nxt  = {len_hi_r, hex[3:0], 1'b0};
          pos_nxt   = 2'd0;
          phase_nxt = ({len_hi_r, hex[3:0]} == 8'd0) ? PH_END : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left_nxt = left_dec;
        if (left_dec == 9'd0) begin
          pos_nxt   = 2'd0;
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        if (char_in != marker_char(end_marker, pos_r)) begin
          res.err   = 1'b1;
          phase_nxt = PH_STOPPED;
        end else if (pos_r == 2'd3) begin
          res.last   = 1'b1;
          pos_nxt    = 2'd0;
          len_hi_nxt = 4'd0;
          left_nxt   = 9'd0;
          phase_nxt  = PH_START;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      default: begin
        // Stopped after an error: swallow everything.
        res.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      pos_r    <= 2'd0;
      len_hi_r <= 4'd0;
      left_r   <= 9'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOPPED |=> phase_r == PH_STOPPED)
    else $error("parser left the stopped phase without reset");

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.emit && res.err |=> phase_r == PH_STOPPED)
    else $error("error result did not stop the parser");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.emit && res.last |=> phase_r == PH_START && pos_r == 2'd0)
    else $error("frame end did not return to start hunting");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 9'd0)
    else $error("payload phase with no characters left");
`endif

endmodule

FILE: tb/hex_text_frame_extractor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the hex-text frame extractor: random framed streams against a predictor.

module hex_text_frame_extractor_test;
  import htfe_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 8;
  localparam int RANDOM_CHARS     = 400;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES      = 8;
  localparam int RUN_LIMIT        = 300000;
  localparam int MAX_REPORTS      = 10;
  localparam int LARGEST_LEN      = 255;

  // Indexes beyond the two marker registers; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;

  typedef enum logic [2:0] {
    HUNT_START, LEN_HIGH, LEN_LOW, PAYLOAD, END_MARK, STOPPED
  } parse_phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } char_result_t;

  class frame_checker;
    logic [MARKER_W-1:0] start_mk;
    logic [MARKER_W-1:0] end_mk;
    parse_phase_e        phase;
    logic [1:0]          pos;
    logic [7:0]          len;
    logic [8:0]          left;
    char_result_t        expected_q[$];
    int                  errors;

    function new();
      start_mk = START_MARKER_RST;
      end_mk   = END_MARKER_RST;
      phase    = HUNT_START;
      pos      = 2'd0;
      len      = 8'd0;
      left     = 9'd0;
      errors   = 0;
    endfunction

    // Bit 4 set when c is not a hex digit.
    static function logic [4:0] digit_value(logic [CHAR_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
      return 5'h10;
    endfunction

    static function logic [CHAR_W-1:0] marker_byte(logic [MARKER_W-1:0] m, logic [1:0] p);
      return 8'(m >> (8 * (3 - int'(p))));
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MARKER_W-1:0] val);
      if (idx == REG_START_MARKER) start_mk = val;
      else if (idx == REG_END_MARKER) end_mk = val;
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      char_result_t r;
      logic [4:0]   d;
      logic         ok;
      r.ch   = c;
      r.last = 1'b0;
      r.err  = 1'b0;
      ok     = 1'b1;
      case (phase)
        HUNT_START: begin
          ok = (c == marker_byte(start_mk, pos));
          if (ok) begin
            if (pos == 2'd3) phase = LEN_HIGH;
            pos = pos + 2'd1;
          end
        end
        LEN_HIGH: begin
          d  = digit_value(c);
          ok = !d[4];
          if (ok) begin
            len   = {d[3:0], 4'h0};
            phase = LEN_LOW;
          end
        end
        LEN_LOW: begin
          d  = digit_value(c);
          ok = !d[4];
          if (ok) begin
            len[3:0] = d[3:0];
            left     = {len, 1'b0};
            pos      = 2'd0;
            phase    = (left == 9'd0) ? END_MARK : PAYLOAD;
          end
        end
        PAYLOAD: begin
          left = left - 9'd1;
          if (left == 9'd0) begin
            pos   = 2'd0;
            phase = END_MARK;
          end
        end
        END_MARK: begin
          ok = (c == marker_byte(end_mk, pos));
          if (ok && pos == 2'd3) begin
            r.last = 1'b1;
            len    = 8'd0;
            left   = 9'd0;
            phase  = HUNT_START;
          end
          if (ok) pos = pos + 2'd1;
        end
        default: return;  // stopped: drop silently
      endcase
      if (!ok) begin
        r.err = 1'b1;
        phase = STOPPED;
      end
      expected_q.push_back(r);
    endfunction

    function void complain(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void check_result(char_result_t got);
      char_result_t want;
      if (expected_q.size() == 0) begin
        complain($sformatf("unexpected result char=%h last=%b err=%b",
                           got.ch, got.last, got.err));
        return;
      end
      want = expected_q.pop_front();
      if (got.ch != want.ch)
        complain($sformatf("out_char expected %h got %h", want.ch, got.ch));
      if (got.last != want.last)
        complain($sformatf("frame_last expected %b got %b (char %h)", want.last, got.last,
                           want.ch));
      if (got.err != want.err)
        complain($sformatf("frame_error expected %b got %b (char %h)", want.err, got.err,
                           want.ch));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flush_check();
      char_result_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        complain($sformatf("missing result char=%h last=%b err=%b",
                           want.ch, want.last, want.err));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  bit   hold_req = 1'b0;
  int   burst_left = 0;
  int   chars_sent = 0;

  logic [MARKER_W-1:0] cur_start = START_MARKER_RST;
  logic [MARKER_W-1:0] cur_end   = END_MARKER_RST;

  frame_checker frames = new();

  htfe_in_if  in_ch();
  htfe_out_if out_ch();
  htfe_cfg_if cfg_ch();

  hex_text_frame_extractor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) frames.note_char(in_ch.in_char);
    if (rst_n && out_ch.valid && out_ch.ready)
      frames.check_result(char_result_t'{out_ch.out_char, out_ch.frame_last,
                                         out_ch.frame_error});
    if (rst_n && cfg_ch.valid && cfg_ch.ready) frames.write_reg(cfg_ch.index, cfg_ch.data);
  end

  // Receiver: stretches of steady accept or random stalls, plus one long hold on request.
  initial begin : receiver
    int stretch;
    bit steady;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stretch = $urandom_range(4, 40);
        steady  = ($urandom_range(0, 3) == 0);
        repeat (stretch) begin
          out_ch.ready <= steady || ($urandom_range(0, 2) != 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("hex_text_frame_extractor_test: errors");
    $finish;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
  endtask

  // Hold the input until every predicted character has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (frames.pending() != 0) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes need no gap; caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MARKER_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_START_MARKER) cur_start = val;
    else if (idx == REG_END_MARKER) cur_end = val;
  endtask

  function automatic logic [MARKER_W-1:0] pick_marker();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return START_MARKER_RST;
      3:       return END_MARKER_RST;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [CHAR_W-1:0] bad_digit();
    logic [CHAR_W-1:0] c;
    logic [4:0]        d;
    // Neighbors of the digit ranges first: '/', ':', '@', 'G', '`', 'g'.
    logic [CHAR_W-1:0] edges[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    if ($urandom_range(0, 1)) return edges[$urandom_range(0, 5)];
    do begin
      c = 8'($urandom_range(0, 255));
      d = frame_checker::digit_value(c);
    end while (!d[4]);
    return c;
  endfunction

  task automatic send_marker(input logic [MARKER_W-1:0] m, input int count);
    for (int i = 0; i < count; i++) send_char(frame_checker::marker_byte(m, 2'(i)));
  endtask

  task automatic send_length(input logic [7:0] n);
    send_char(hex_char(n[7:4]));
    send_char(hex_char(n[3:0]));
  endtask

  task automatic send_frame(input logic [7:0] n, input bit mid_write);
    send_marker(cur_start, 4);
    send_length(n);
    if (mid_write) begin
      // Change markers with the parser mid-frame; the new end marker applies at once.
      drain_results();
      write_reg(REG_END_MARKER, pick_marker());
      if ($urandom_range(0, 1)) write_reg(REG_START_MARKER, pick_marker());
      cfg_ch.valid <= 1'b0;
    end
    repeat (2 * int'(n)) send_char(8'($urandom_range(0, 255)));
    send_marker(cur_end, 4);
  endtask

  task automatic reconfigure();
    drain_results();
    case ($urandom_range(0, 3))
      0: write_reg(REG_START_MARKER, pick_marker());
      1: write_reg(REG_END_MARKER, pick_marker());
      2: write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      default: begin
        write_reg(REG_START_MARKER, pick_marker());
        write_reg(REG_END_MARKER, pick_marker());
      end
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // Any error stops the block until reset, so only one broken frame fits in a run.
  task automatic send_broken_frame();
    int          p;
    logic [7:0]  n;
    p = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: begin
        send_marker(cur_start, p);
        send_char(frame_checker::marker_byte(cur_start, 2'(p)) ^ 8'($urandom_range(1, 255)));
      end
      1: begin
        send_marker(cur_start, 4);
        send_char(bad_digit());
      end
      2: begin
        send_marker(cur_start, 4);
        send_char(hex_char(4'($urandom_range(0, 15))));
        send_char(bad_digit());
      end
      default: begin
        n = 8'($urandom_range(0, 4));
        send_marker(cur_start, 4);
        send_length(n);
        repeat (2 * int'(n)) send_char(8'($urandom_range(0, 255)));
        send_marker(cur_end, p);
        send_char(frame_checker::marker_byte(cur_end, 2'(p)) ^ 8'($urandom_range(1, 255)));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0] n;
    bit         hold_done;
    hold_done     = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_char <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_START_MARKER;
    cfg_ch.data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset markers, zero length: end marker right after the digits.
    send_frame(8'h00, 1'b0);
    drain_results();
    write_reg(REG_START_MARKER, '0);
    write_reg(REG_END_MARKER, '1);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    cfg_ch.valid <= 1'b0;
    // Extreme payload values under extreme markers.
    send_marker(cur_start, 4);
    send_length(8'h01);
    send_char(8'h00);
    send_char(8'hFF);
    send_marker(cur_end, 4);

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if ($urandom_range(0, 5) == 0) reconfigure();
      if (!hold_done && chars_sent > 120) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
        n = 8'd24;
      end else if ($urandom_range(0, 7) == 0) begin
        n = 8'($urandom_range(8, 40));
      end else begin
        n = 8'($urandom_range(0, 6));
      end
      send_frame(n, $urandom_range(0, 7) == 0);
    end
    send_frame(8'(LARGEST_LEN), 1'b0);

    send_broken_frame();
    drain_results();
    // Stopped now: these must produce nothing.
    repeat (16) send_char(8'($urandom_range(0, 255)));
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    frames.flush_check();
    if (frames.errors == 0) $display("hex_text_frame_extractor_test: clean");
    else $display("hex_text_frame_extractor_test: errors");
    $finish;
  end

endmodule
